[rtl/core/thgd_pkg.sv]
// thgd_pkg: shared types and constants for the touch hold gesture detector
// event codes, action codes, register map and sequencer states
// no dependencies
package thgd_pkg;

  localparam int unsigned CoordWidthDef = 12;
  localparam int unsigned FuncW         = 3;
  localparam int unsigned CountW        = 4;
  localparam int unsigned TickW         = 10;
  localparam int unsigned LimW          = 12;
  localparam int unsigned MsW           = 16;
  localparam int unsigned ElapsedW      = 17;
  localparam int unsigned FingerW       = 5;
  localparam int unsigned ActionW       = 2;
  localparam int unsigned ProgW         = 8;
  localparam int unsigned OutDataW      = 16;
  localparam int unsigned ApbAddrW      = 4;
  localparam int unsigned ApbDataW      = 32;
  localparam int unsigned DivSteps      = 8;
  localparam int unsigned MaxFingers    = 2;

  localparam logic [ElapsedW-1:0] ElapsedMax  = '1;
  localparam logic [MsW-1:0]      DeadZoneRst = 16'd500;
  localparam logic [MsW-1:0]      FillRst     = 16'd1000;
  localparam logic [LimW-1:0]     MoveLimRst  = 12'd15;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_BEGIN  = 3'd1,
    FUNC_MOVE   = 3'd2,
    FUNC_END    = 3'd3,
    FUNC_CANCEL = 3'd4
  } func_e;

  typedef enum logic [ActionW-1:0] {
    ACT_NONE   = 2'd0,
    ACT_MENU   = 2'd1,
    ACT_EDITOR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_DEAD_ZONE  = 2'd0,
    REG_FILL       = 2'd1,
    REG_MOVE_LIMIT = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_MUL,
    ST_APPLY,
    ST_PREP,
    ST_SCALE,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

[rtl/core/touch_hold_gesture_detector_top.sv]
// touch_hold_gesture_detector_top: long-press detector with stream ports and apb registers
// one sequencer drives a shared squaring multiplier and a serial compare-subtract divider
// depends on thgd_pkg
//
// Takes one event item at a time and returns one status item per event. The result
// register loads in ST_OUT after the sequence (ST_TICK for a tick or ST_MUL for a move,
// then ST_APPLY, ST_PREP, ST_SCALE, ST_DIV), and tready returns in the cycle after, so
// no new item is taken before the last one is through, nor while the previous result
// waits on m_axis_tready; tready is low meanwhile. Most of the sequence is spent in the
// progress divider, which finds the 8-bit fill fraction one quotient bit per cycle after
// a clamp check, and for moves in the single multiplier that squares dx, dy and the limit
// in three passes. The result register lets a new item in while the last result waits.
// Registers at byte address 0 (dead zone ms), 4 (fill ms), 8 (move limit px) and may
// only be written while no item is in flight.
module touch_hold_gesture_detector_top #(
  parameter int unsigned COORD_WIDTH = thgd_pkg::CoordWidthDef,
  localparam int unsigned InW     = thgd_pkg::CountW + 2 * COORD_WIDTH + thgd_pkg::TickW + 1,
  localparam int unsigned InDataW = ((InW + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // touch_count, x_pos, y_pos, tick_ms, hold_allowed, zero pad
  input  logic [InDataW-1:0]              s_axis_tdata,
  // func
  input  logic [thgd_pkg::FuncW-1:0]      s_axis_tuser,
  // stream out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // action, bar_visible, progress, holding, zero pad
  output logic [thgd_pkg::OutDataW-1:0]   m_axis_tdata,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [thgd_pkg::ApbAddrW-1:0]   paddr,
  input  logic [thgd_pkg::ApbDataW-1:0]   pwdata,
  output logic [thgd_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  localparam int unsigned CW      = COORD_WIDTH;
  localparam int unsigned MulW    = (CW > thgd_pkg::LimW) ? CW : thgd_pkg::LimW;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned DistW   = ProdW + 1;
  localparam int unsigned EW      = thgd_pkg::ElapsedW;
  localparam int unsigned NumW    = EW + thgd_pkg::ProgW;
  localparam int unsigned DcntW   = $clog2(thgd_pkg::DivSteps + 1);
  localparam int unsigned XLo     = thgd_pkg::CountW;
  localparam int unsigned YLo     = XLo + CW;
  localparam int unsigned TickLo  = YLo + CW;
  localparam int unsigned AllowAt = TickLo + thgd_pkg::TickW;
  localparam int unsigned OutPad  = thgd_pkg::OutDataW - thgd_pkg::ActionW - thgd_pkg::ProgW - 2;

  // sequencer
  thgd_pkg::state_e state_q, state_d;
  logic             out_load;

  // captured item
  thgd_pkg::func_e              func_q;
  logic [thgd_pkg::CountW-1:0]  cnt_q;
  logic [CW-1:0]                x_q, y_q;
  logic [thgd_pkg::TickW-1:0]   tick_q;
  logic                         allow_q;

  // gesture state
  logic                         armed_q, done_q, bar_on_q;
  logic [thgd_pkg::FingerW-1:0] fingers_q;
  logic [EW-1:0]                elapsed_q;
  logic [CW-1:0]                start_x_q, start_y_q;
  thgd_pkg::action_e            action_q;

  // registers
  logic [thgd_pkg::MsW-1:0]     dz_q, fill_q;
  logic [thgd_pkg::LimW-1:0]    lim_q;

  // arithmetic working registers
  logic [1:0]                   mcnt_q;
  logic [ProdW-1:0]             prod_q;
  logic [DistW-1:0]             dist_q;
  logic                         zero_q, sat_q;
  logic [EW-1:0]                over_q;
  logic [EW-1:0]                rem_q;
  logic [thgd_pkg::ProgW-1:0]   low_q, quo_q;
  logic [DcntW-1:0]             dcnt_q;

  logic                         m_valid_q;
  logic [thgd_pkg::OutDataW-1:0] m_data_q;

  // combinational datapath
  logic                         in_acc, cfg_wr;
  logic [CW-1:0]                dx, dy;
  logic [MulW-1:0]              mul_a;
  logic [ProdW-1:0]             mul_sq;
  logic [EW:0]                  tick_sum;
  logic [EW-1:0]                end_ms;
  logic [thgd_pkg::FingerW:0]   f_sum;
  logic [EW:0]                  dz_diff;
  logic [NumW-1:0]              num;
  logic [EW-1:0]                shifted;
  logic [EW:0]                  trial;
  logic [thgd_pkg::ProgW-1:0]   progress;

  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign cfg_wr = psel & penable & pwrite & pready;

  assign dx = (x_q >= start_x_q) ? (x_q - start_x_q) : (start_x_q - x_q);
  assign dy = (y_q >= start_y_q) ? (y_q - start_y_q) : (start_y_q - y_q);

  always_comb begin
    case (mcnt_q)
      2'd0:    mul_a = MulW'(dx);
      2'd1:    mul_a = MulW'(dy);
      default: mul_a = MulW'(lim_q);
    endcase
  end

  // shared squaring unit
  assign mul_sq   = mul_a * mul_a;
  assign tick_sum = {1'b0, elapsed_q} + (EW + 1)'(tick_q);
  assign end_ms   = {1'b0, dz_q} + {1'b0, fill_q};
  assign f_sum    = {1'b0, fingers_q} + (thgd_pkg::FingerW + 1)'(cnt_q);
  assign dz_diff  = {1'b0, elapsed_q} - (EW + 1)'(dz_q);
  // over * 255 as a shift and subtract
  assign num      = {over_q, {thgd_pkg::ProgW{1'b0}}} - NumW'(over_q);
  assign shifted  = {rem_q[EW-2:0], low_q[thgd_pkg::ProgW-1]};
  assign trial    = {1'b0, shifted} - (EW + 1)'(fill_q);
  assign progress = zero_q ? '0 : (sat_q ? '1 : quo_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      thgd_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (thgd_pkg::func_e'(s_axis_tuser) == thgd_pkg::FUNC_TICK) begin
            state_d = thgd_pkg::ST_TICK;
          end else if (thgd_pkg::func_e'(s_axis_tuser) == thgd_pkg::FUNC_MOVE) begin
            state_d = thgd_pkg::ST_MUL;
          end else begin
            state_d = thgd_pkg::ST_APPLY;
          end
        end
      end
      thgd_pkg::ST_TICK:  state_d = thgd_pkg::ST_APPLY;
      thgd_pkg::ST_MUL: begin
        if (mcnt_q == 2'd2) state_d = thgd_pkg::ST_APPLY;
      end
      thgd_pkg::ST_APPLY: state_d = thgd_pkg::ST_PREP;
      thgd_pkg::ST_PREP:  state_d = thgd_pkg::ST_SCALE;
      thgd_pkg::ST_SCALE: state_d = thgd_pkg::ST_DIV;
      thgd_pkg::ST_DIV: begin
        if (dcnt_q == DcntW'(thgd_pkg::DivSteps)) state_d = thgd_pkg::ST_OUT;
      end
      thgd_pkg::ST_OUT: begin
        if (out_load) state_d = thgd_pkg::ST_IDLE;
      end
      default: state_d = thgd_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      thgd_pkg::ST_IDLE: s_axis_tready = 1'b1;
      thgd_pkg::ST_OUT:  out_load = ~m_valid_q | m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= thgd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q   <= thgd_pkg::DeadZoneRst;
      fill_q <= thgd_pkg::FillRst;
      lim_q  <= thgd_pkg::MoveLimRst;
    end else if (cfg_wr) begin
      unique case (thgd_pkg::reg_e'(paddr[3:2]))
        thgd_pkg::REG_DEAD_ZONE:  dz_q   <= pwdata[thgd_pkg::MsW-1:0];
        thgd_pkg::REG_FILL:       fill_q <= pwdata[thgd_pkg::MsW-1:0];
        thgd_pkg::REG_MOVE_LIMIT: lim_q  <= pwdata[thgd_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (thgd_pkg::reg_e'(paddr[3:2]))
      thgd_pkg::REG_DEAD_ZONE:  prdata = thgd_pkg::ApbDataW'(dz_q);
      thgd_pkg::REG_FILL:       prdata = thgd_pkg::ApbDataW'(fill_q);
      thgd_pkg::REG_MOVE_LIMIT: prdata = thgd_pkg::ApbDataW'(lim_q);
      default:                  prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // item capture and working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q  <= thgd_pkg::func_e'(s_axis_tuser);
      cnt_q   <= s_axis_tdata[thgd_pkg::CountW-1:0];
      x_q     <= s_axis_tdata[XLo +: CW];
      y_q     <= s_axis_tdata[YLo +: CW];
      tick_q  <= s_axis_tdata[TickLo +: thgd_pkg::TickW];
      allow_q <= s_axis_tdata[AllowAt];
    end
    unique case (state_q)
      thgd_pkg::ST_MUL: begin
        prod_q <= mul_sq;
        if (mcnt_q == 2'd1) dist_q <= DistW'(prod_q);
        if (mcnt_q == 2'd2) dist_q <= dist_q + DistW'(prod_q);
      end
      thgd_pkg::ST_PREP: begin
        zero_q <= ~bar_on_q | dz_diff[EW];
        over_q <= dz_diff[EW-1:0];
      end
      thgd_pkg::ST_SCALE: begin
        rem_q <= num[NumW-1:thgd_pkg::ProgW];
        low_q <= num[thgd_pkg::ProgW-1:0];
        quo_q <= '0;
      end
      thgd_pkg::ST_DIV: begin
        if (dcnt_q == '0) begin
          // quotient would not fit in eight bits
          sat_q <= (rem_q >= EW'(fill_q));
        end else begin
          low_q <= {low_q[thgd_pkg::ProgW-2:0], 1'b0};
          quo_q <= {quo_q[thgd_pkg::ProgW-2:0], ~trial[EW]};
          rem_q <= trial[EW] ? shifted : trial[EW-1:0];
        end
      end
      default: ;
    endcase
  end

  // counters, gesture state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q    <= '0;
      dcnt_q    <= '0;
      armed_q   <= 1'b0;
      done_q    <= 1'b0;
      bar_on_q  <= 1'b0;
      fingers_q <= '0;
      elapsed_q <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
      action_q  <= thgd_pkg::ACT_NONE;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_axis_tready && !out_load) m_valid_q <= 1'b0;
      unique case (state_q)
        thgd_pkg::ST_IDLE: begin
          mcnt_q   <= '0;
          dcnt_q   <= '0;
          action_q <= thgd_pkg::ACT_NONE;
        end
        thgd_pkg::ST_TICK: begin
          if (armed_q && !done_q) begin
            elapsed_q <= tick_sum[EW] ? thgd_pkg::ElapsedMax : tick_sum[EW-1:0];
          end
        end
        thgd_pkg::ST_MUL: mcnt_q <= mcnt_q + 2'd1;
        thgd_pkg::ST_APPLY: begin
          case (func_q)
            thgd_pkg::FUNC_TICK: begin
              if (armed_q && !done_q && elapsed_q >= EW'(dz_q)) begin
                if (elapsed_q >= end_ms) begin
                  bar_on_q <= 1'b0;
                  done_q   <= 1'b1;
                  action_q <= (fingers_q >= thgd_pkg::FingerW'(thgd_pkg::MaxFingers))
                              ? thgd_pkg::ACT_EDITOR : thgd_pkg::ACT_MENU;
                end else begin
                  bar_on_q <= 1'b1;
                end
              end
            end
            thgd_pkg::FUNC_BEGIN: begin
              if (allow_q) begin
                if (!armed_q) begin
                  armed_q   <= 1'b1;
                  fingers_q <= thgd_pkg::FingerW'(cnt_q);
                  elapsed_q <= '0;
                  done_q    <= 1'b0;
                  bar_on_q  <= 1'b0;
                  if (cnt_q != '0) begin
                    start_x_q <= x_q;
                    start_y_q <= y_q;
                  end
                end else if (!done_q) begin
                  fingers_q <= (f_sum > (thgd_pkg::FingerW + 1)'(thgd_pkg::MaxFingers))
                               ? thgd_pkg::FingerW'(thgd_pkg::MaxFingers)
                               : f_sum[thgd_pkg::FingerW-1:0];
                end
              end
            end
            thgd_pkg::FUNC_MOVE: begin
              // prod_q holds the squared limit here
              if (armed_q && !done_q && cnt_q != '0 && dist_q > DistW'(prod_q)) begin
                armed_q   <= 1'b0;
                done_q    <= 1'b0;
                bar_on_q  <= 1'b0;
                fingers_q <= '0;
                elapsed_q <= '0;
              end
            end
            thgd_pkg::FUNC_END: begin
              if (armed_q) begin
                if (thgd_pkg::FingerW'(cnt_q) >= fingers_q) begin
                  armed_q   <= 1'b0;
                  done_q    <= 1'b0;
                  bar_on_q  <= 1'b0;
                  fingers_q <= '0;
                  elapsed_q <= '0;
                end else begin
                  fingers_q <= fingers_q - thgd_pkg::FingerW'(cnt_q);
                end
              end
            end
            thgd_pkg::FUNC_CANCEL: begin
              armed_q   <= 1'b0;
              done_q    <= 1'b0;
              bar_on_q  <= 1'b0;
              fingers_q <= '0;
              elapsed_q <= '0;
            end
            default: ;
          endcase
        end
        thgd_pkg::ST_DIV: dcnt_q <= dcnt_q + DcntW'(1);
        thgd_pkg::ST_OUT: begin
          if (out_load) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {{OutPad{1'b0}}, armed_q, progress, bar_on_q, action_q};
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // a finished gesture stays armed until something clears it
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> armed_q)
    else $error("done without armed");

  // the bar is only shown on a live, unfinished hold
  assert property (@(posedge clk_i) disable iff (!rst_ni) bar_on_q |-> (armed_q && !done_q))
    else $error("bar shown outside a live hold");

  // one item in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> !s_axis_tready)
    else $error("item accepted while busy");

  // an action comes only with the bar hidden and the hold still armed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[thgd_pkg::ActionW-1:0] != thgd_pkg::ACT_NONE)
    |-> (!m_axis_tdata[thgd_pkg::ActionW] && m_axis_tdata[thgd_pkg::ActionW+thgd_pkg::ProgW+1]))
    else $error("action with bar shown or hold not armed");

endmodule
